>>> src/rau_pkg.sv
package rau_pkg;

    localparam int OperandWidth = 16;
    localparam int ProdWidth    = 2 * OperandWidth;
    localparam int SumWidth     = ProdWidth + 1;
    localparam int CntWidth     = $clog2(SumWidth + 1);

    typedef enum logic [2:0] {
        OP_REDUCE  = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_CMP     = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]  op;
        logic signed [OperandWidth-1:0] a_num;
        logic signed [OperandWidth-1:0] a_den;
        logic signed [OperandWidth-1:0] b_num;
        logic signed [OperandWidth-1:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0] res_den;
        logic        less;
        logic        equal;
        logic        greater;
        logic        fault;
    } t_out_item;

    // shared divider control
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> src/rau_div.sv
module rau_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rau_pkg::t_div_ctl             i_ctl,
    input  logic [rau_pkg::SumWidth-1:0]  i_dividend,
    input  logic [rau_pkg::SumWidth-1:0]  i_divisor,
    output rau_pkg::t_div_sts             o_sts,
    output logic [rau_pkg::SumWidth-1:0]  o_quot,
    output logic [rau_pkg::SumWidth-1:0]  o_rem
);
    import rau_pkg::*;

    logic [SumWidth-1:0] r_quot, n_quot;
    logic [SumWidth-1:0] r_rem, n_rem;
    logic [SumWidth-1:0] r_dvs, n_dvs;
    logic [CntWidth-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [SumWidth:0]   w_trial;
    logic [SumWidth:0]   w_diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_quot[SumWidth-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (i_ctl.start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_cnt  = CntWidth'(SumWidth);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[SumWidth]) begin
                n_rem  = w_diff[SumWidth-1:0];
                n_quot = {r_quot[SumWidth-2:0], 1'b1};
            end else begin
                n_rem  = w_trial[SumWidth-1:0];
                n_quot = {r_quot[SumWidth-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntWidth'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;
    assign o_rem      = r_rem;

endmodule

>>> src/rational_arithmetic_unit.sv
// each gcd step and each of the two reducing divisions runs on the divider
// gcd steps are bounded by the euclid depth (at most about 47); compare items and operand faults skip the divider
// throughput: one item at a time, busy stays high from accept through S_DONE and is low again while o_valid is high
// reset: synchronous active-low i_rst_n returns the sequencer to idle
// results are strobed for one cycle on o_valid; the receiver cannot stall
module rational_arithmetic_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rau_pkg::t_in_item    i_item,
    output logic                 o_valid,
    output rau_pkg::t_out_item   o_item
);
    import rau_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_SUM   = 8'b0000_0100,
        S_GCD   = 8'b0000_1000,
        S_GWAIT = 8'b0001_0000,
        S_RNUM  = 8'b0010_0000,
        S_RDEN  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // operand sign/magnitude registers
    logic [2:0]            r_op;
    logic                  r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [OperandWidth-1:0] r_an, r_ad, r_bn, r_bd;
    // products
    logic [ProdWidth-1:0]  r_p1, r_p2, r_p3;
    logic                  r_p1_s, r_p2_s;
    // working values
    logic [SumWidth-1:0]   r_num, r_den, r_gx, r_gy, r_g, r_rn;
    logic                  r_neg;
    logic                  r_fault, r_less, r_equal, r_greater;
    logic                  r_valid;

    // shared divider
    t_div_ctl              w_dctl;
    t_div_sts              w_dsts;
    logic [SumWidth-1:0]   w_dvd, w_dvs, w_quot, w_rem;

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_dctl),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_sts      (w_dsts),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // operand split into sign and magnitude
    function automatic logic [OperandWidth:0] f_sm(input logic [OperandWidth-1:0] raw);
        logic [OperandWidth-1:0] v;
        v = raw;
        if (v[OperandWidth-1]) begin
            return {1'b1, OperandWidth'(-v)};
        end
        return {1'b0, v};
    endfunction

    logic [OperandWidth:0] w_an, w_ad, w_bn, w_bd;
    assign w_an = f_sm(i_item.a_num);
    assign w_ad = f_sm(i_item.a_den);
    assign w_bn = f_sm(i_item.b_num);
    assign w_bd = f_sm(i_item.b_den);

    // signed sum of the two cross products (p1 and p2)
    logic [SumWidth-1:0] w_sum;
    logic                w_sum_s;
    logic [SumWidth-1:0] w_e1, w_e2;
    assign w_e1 = {1'b0, r_p1};
    assign w_e2 = {1'b0, r_p2};
    always_comb begin
        if (r_p1_s == r_p2_s) begin
            w_sum   = w_e1 + w_e2;
            w_sum_s = r_p1_s;
        end else if (w_e1 >= w_e2) begin
            w_sum   = w_e1 - w_e2;
            w_sum_s = r_p1_s;
        end else begin
            w_sum   = w_e2 - w_e1;
            w_sum_s = r_p2_s;
        end
        if (w_sum == '0) begin
            w_sum_s = 1'b0;
        end
    end

    // compare of cross products: -1/0/+1 as lt/eq
    logic w_lt, w_eq;
    always_comb begin
        logic xs, ys;
        xs = r_p1_s && (r_p1 != '0);
        ys = r_p2_s && (r_p2 != '0);
        w_eq = (xs == ys) && (r_p1 == r_p2);
        if (xs != ys) begin
            w_lt = xs;
        end else if (r_p1 < r_p2) begin
            w_lt = !xs;
        end else begin
            w_lt = xs && !w_eq;
        end
    end

    assign busy = (r_state != S_IDLE);

    logic w_accept;
    assign w_accept = start && !busy;

    // divider hookup
    always_comb begin
        w_dctl.start = 1'b0;
        w_dvd = r_gy;
        w_dvs = r_gx;
        case (r_state)
            S_GCD: begin
                w_dctl.start = (r_gx != '0);
            end
            S_RNUM: begin
                w_dvd = r_num;
                w_dvs = r_g;
                w_dctl.start = !w_dsts.busy && !w_dsts.done;
            end
            S_RDEN: begin
                w_dvd = r_den;
                w_dvs = r_g;
                w_dctl.start = !w_dsts.busy && !w_dsts.done;
            end
            default: begin
                w_dctl.start = 1'b0;
            end
        endcase
    end

    logic r_rstarted;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_MUL;
            S_MUL:   n_state = r_fault ? S_DONE : S_SUM;
            S_SUM:   n_state = (r_fault || r_op == OP_CMP) ? S_DONE : S_GCD;
            S_GCD:   n_state = (r_gx == '0) ? S_RNUM : S_GWAIT;
            S_GWAIT: if (w_dsts.done) n_state = S_GCD;
            S_RNUM:  if (w_dsts.done && r_rstarted) n_state = S_RDEN;
            S_RDEN:  if (w_dsts.done && r_rstarted) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [SumWidth-1:0] w_rd;
    logic                w_ovf;
    always_comb begin
        w_rd  = w_quot;
        w_ovf = (w_rd > SumWidth'(32'h7FFF_FFFF)) ||
                (r_neg ? (r_rn > SumWidth'(32'h8000_0000))
                       : (r_rn > SumWidth'(32'h7FFF_FFFF)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_rstarted <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_DONE);
            if (w_dctl.start) begin
                r_rstarted <= 1'b1;
            end else if (w_dsts.done) begin
                r_rstarted <= 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                r_op   <= i_item.op;
                {r_an_s, r_an} <= w_an;
                {r_ad_s, r_ad} <= w_ad;
                {r_bn_s, r_bn} <= w_bn;
                {r_bd_s, r_bd} <= w_bd;
                r_less    <= 1'b0;
                r_equal   <= 1'b0;
                r_greater <= 1'b0;
                r_fault   <= (i_item.op > OP_CMP) || (w_ad[OperandWidth-1:0] == '0) ||
                             ((i_item.op != OP_REDUCE) && (w_bd[OperandWidth-1:0] == '0)) ||
                             ((i_item.op == OP_DIV) && (w_bn[OperandWidth-1:0] == '0));
            end
            S_MUL: begin
                // p1 = num part, p2 = second cross term, p3 = denominator
                case (r_op)
                    OP_REDUCE: begin
                        r_p1 <= ProdWidth'(r_an); r_p1_s <= r_an_s;
                        r_p2 <= '0;              r_p2_s <= 1'b0;
                        r_p3 <= ProdWidth'(r_ad);
                    end
                    OP_MUL: begin
                        r_p1 <= r_an * r_bn; r_p1_s <= r_an_s ^ r_bn_s;
                        r_p2 <= '0;          r_p2_s <= 1'b0;
                        r_p3 <= r_ad * r_bd;
                    end
                    OP_DIV: begin
                        r_p1 <= r_an * r_bd; r_p1_s <= r_an_s ^ r_bd_s;
                        r_p2 <= '0;          r_p2_s <= 1'b0;
                        r_p3 <= r_ad * r_bn;
                    end
                    default: begin
                        r_p1 <= r_an * r_bd; r_p1_s <= r_an_s ^ r_bd_s;
                        r_p2 <= r_bn * r_ad;
                        r_p2_s <= r_bn_s ^ r_ad_s ^ (r_op == OP_SUB);
                        r_p3 <= r_ad * r_bd;
                    end
                endcase
            end
            S_SUM: begin
                r_num <= w_sum;
                r_den <= {1'b0, r_p3};
                r_gx  <= w_sum;
                r_gy  <= {1'b0, r_p3};
                case (r_op)
                    OP_REDUCE: r_neg <= w_sum_s ^ r_ad_s;
                    OP_MUL:    r_neg <= w_sum_s ^ r_ad_s ^ r_bd_s;
                    OP_DIV:    r_neg <= w_sum_s ^ r_ad_s ^ r_bn_s;
                    default:   r_neg <= w_sum_s ^ r_ad_s ^ r_bd_s;
                endcase
                if (r_op == OP_CMP) begin
                    // flip orientation when ad*bd is negative
                    r_equal   <= w_eq;
                    r_less    <= !w_eq && (w_lt ^ (r_ad_s ^ r_bd_s));
                    r_greater <= !w_eq && !(w_lt ^ (r_ad_s ^ r_bd_s));
                end
            end
            S_GCD: begin
                if (r_gx == '0) begin
                    r_g <= r_gy;
                end
            end
            S_GWAIT: begin
                if (w_dsts.done) begin
                    r_gy <= r_gx;
                    r_gx <= w_rem;
                end
            end
            S_RNUM: begin
                if (w_dsts.done && r_rstarted) begin
                    r_rn <= w_quot;
                    if (w_quot == '0) begin
                        r_neg <= 1'b0;
                    end
                end
            end
            S_RDEN: begin
                if (w_dsts.done && r_rstarted) begin
                    if (w_ovf) begin
                        r_fault <= 1'b1;
                    end
                    r_den <= w_rd;
                end
            end
            default: begin
            end
        endcase
    end

    // result item: all zero but the fault flag on error, only flags on compare
    t_out_item w_res;
    always_comb begin
        w_res = '0;
        if (r_fault) begin
            w_res.fault = 1'b1;
        end else if (r_op == OP_CMP) begin
            w_res.less    = r_less;
            w_res.equal   = r_equal;
            w_res.greater = r_greater;
        end else begin
            w_res.res_num = r_neg ? -(r_rn[31:0]) : r_rn[31:0];
            w_res.res_den = r_den[30:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_item <= w_res;
        end
    end

    assign o_valid = r_valid;

endmodule

>>> sim/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int NUM_RANDOM = 530;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_valid;
    t_out_item o_item;

    rational_arithmetic_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_item (i_item),
        .o_valid(o_valid),
        .o_item (o_item)
    );

    // expected results, oldest first
    t_out_item pending_results[$];
    int        fail_count = 0;

    // one row of the directed table; has_golden marks a result typed in by hand
    typedef struct {
        t_in_item  item;
        logic      has_golden;
        t_out_item golden;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // signed magnitude helpers at 64 bits, wide enough for every cross product
    function automatic logic [63:0] mag_of(logic signed [15:0] v);
        return (v < 0) ? 64'(-32'(v)) : 64'(v);
    endfunction

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (x != 0) begin
            t = x;
            x = y % x;
            y = t;
        end
        return y;
    endfunction

    // exact rational result of one item
    function automatic t_out_item predict_rational(t_in_item it);
        t_out_item   r;
        logic [63:0] an, ad, bn, bd, xm, ym, nm, dm, g, rn, rd;
        logic        ans, ads, bns, bds, xs, ys, ns, ds, neg;
        int          c;
        r = '0;
        an = mag_of(it.a_num); ans = it.a_num < 0;
        ad = mag_of(it.a_den); ads = it.a_den < 0;
        bn = mag_of(it.b_num); bns = it.b_num < 0;
        bd = mag_of(it.b_den); bds = it.b_den < 0;
        if (it.op > OP_CMP || ad == 0 || (it.op != OP_REDUCE && bd == 0)) begin
            r.fault = 1'b1;
            return r;
        end
        if (it.op == OP_CMP) begin
            // cross products, then flip when ad*bd is negative
            xm = an * bd; xs = (xm != 0) && (ans != bds);
            ym = bn * ad; ys = (ym != 0) && (bns != ads);
            if (xs != ys) c = xs ? -1 : 1;
            else if (xm == ym) c = 0;
            else if (xm < ym) c = xs ? 1 : -1;
            else c = xs ? -1 : 1;
            if (ads != bds) c = -c;
            r.less = c < 0;
            r.equal = c == 0;
            r.greater = c > 0;
            return r;
        end
        if (it.op == OP_SUB) bns = ~bns;
        case (it.op)
            OP_REDUCE: begin
                nm = an; ns = ans; dm = ad; ds = ads;
            end
            OP_ADD, OP_SUB: begin
                xm = an * bd; xs = ans != bds;
                ym = bn * ad; ys = bns != ads;
                if (xm == 0) xs = 1'b0;
                if (ym == 0) ys = 1'b0;
                if (xs == ys) begin
                    nm = xm + ym; ns = xs;
                end else if (xm >= ym) begin
                    nm = xm - ym; ns = xs;
                end else begin
                    nm = ym - xm; ns = ys;
                end
                dm = ad * bd; ds = ads != bds;
            end
            OP_MUL: begin
                nm = an * bn; ns = ans != bns;
                dm = ad * bd; ds = ads != bds;
            end
            default: begin
                if (bn == 0) begin
                    r.fault = 1'b1;
                    return r;
                end
                nm = an * bd; ns = ans != bds;
                dm = ad * bn; ds = ads != bns;
            end
        endcase
        g = euclid_gcd(nm, dm);
        rn = nm / g;
        rd = dm / g;
        neg = (rn != 0) && (ns != ds);
        if (rd > 64'h7FFF_FFFF || (neg ? rn > 64'h8000_0000 : rn > 64'h7FFF_FFFF)) begin
            r.fault = 1'b1;
            return r;
        end
        r.res_num = neg ? -(rn[31:0]) : rn[31:0];
        r.res_den = rd[30:0];
        return r;
    endfunction

    // random operand: full-range values most often, small magnitudes so results reduce, sometimes extremes or zero
    function automatic logic signed [15:0] draw_part();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd0;
            3, 4, 5: return 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    // start stays high across a zero idle draw, so it is assigned once per time step
    task automatic send_item(t_in_item it);
        int idle;
        idle = $urandom_range(0, 3);
        if (idle != 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_rational(it));
    endtask

    // result check; the receiver cannot stall, so sample every strobe
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_item.res_num !== want.res_num) begin
                    $error("res_num expected %0d actual %0d", want.res_num, o_item.res_num);
                    fail_count++;
                end
                if (o_item.res_den !== want.res_den) begin
                    $error("res_den expected %0d actual %0d", want.res_den, o_item.res_den);
                    fail_count++;
                end
                if (o_item.less !== want.less) begin
                    $error("less expected %0b actual %0b", want.less, o_item.less);
                    fail_count++;
                end
                if (o_item.equal !== want.equal) begin
                    $error("equal expected %0b actual %0b", want.equal, o_item.equal);
                    fail_count++;
                end
                if (o_item.greater !== want.greater) begin
                    $error("greater expected %0b actual %0b", want.greater, o_item.greater);
                    fail_count++;
                end
                if (o_item.fault !== want.fault) begin
                    $error("fault expected %0b actual %0b", want.fault, o_item.fault);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_row     rows[$];
        t_in_item it;
        t_out_item flt;
        t_out_item gold;
        int       waited;

        flt = '0;
        flt.fault = 1'b1;

        // directed table: opcode, a_num, a_den, b_num, b_den
        rows.push_back('{'{OP_REDUCE, 16'sd6, 16'sd4, 16'sd0, 16'sd0}, 1'b1,
                         '{32'sd3, 31'd2, 1'b0, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{'{OP_REDUCE, 16'sd0, -16'sd5, 16'sd1, 16'sd1}, 1'b1,
                         '{32'sd0, 31'd1, 1'b0, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{'{OP_REDUCE, 16'sd3, 16'sd0, 16'sd1, 16'sd1}, 1'b1, flt});
        rows.push_back('{'{OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd0}, 1'b1, flt});
        rows.push_back('{'{OP_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd7}, 1'b1, flt});
        rows.push_back('{'{3'd6, 16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b1, flt});
        rows.push_back('{'{3'd7, 16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b1, flt});
        rows.push_back('{'{OP_CMP, 16'sd1, -16'sd2, 16'sd1, 16'sd3}, 1'b1,
                         '{32'sd0, 31'd0, 1'b1, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{'{OP_CMP, 16'sd2, 16'sd4, -16'sd1, -16'sd2}, 1'b1,
                         '{32'sd0, 31'd0, 1'b0, 1'b1, 1'b0, 1'b0}});
        rows.push_back('{'{OP_REDUCE, 16'sh8000, -16'sd1, 16'sd0, 16'sd0}, 1'b1,
                         '{32'sd32768, 31'd1, 1'b0, 1'b0, 1'b0, 1'b0}});
        // extremes and sign mixes, checked by the predictor
        rows.push_back('{'{OP_ADD, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b0, '0});
        rows.push_back('{'{OP_SUB, 16'sh8000, 16'sd1, 16'sh7FFF, 16'sd1}, 1'b0, '0});
        rows.push_back('{'{OP_SUB, 16'sd1, 16'sd3, 16'sd1, 16'sd3}, 1'b0, '0});
        rows.push_back('{'{OP_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1}, 1'b0, '0});
        rows.push_back('{'{OP_MUL, 16'sh8000, 16'sd1, 16'sh8000, -16'sd1}, 1'b0, '0});
        rows.push_back('{'{OP_MUL, 16'sd1, 16'sh8000, 16'sd1, 16'sh8000}, 1'b0, '0});
        rows.push_back('{'{OP_MUL, 16'sd1, 16'sh7FFF, 16'sd1, 16'sh7FFF}, 1'b0, '0});
        rows.push_back('{'{OP_DIV, 16'sh8000, 16'sd1, 16'sd1, 16'sh8000}, 1'b0, '0});
        rows.push_back('{'{OP_DIV, -16'sd3, 16'sd4, -16'sd9, -16'sd8}, 1'b0, '0});
        rows.push_back('{'{OP_ADD, -16'sd1, 16'sd2, 16'sd1, -16'sd2}, 1'b0, '0});
        rows.push_back('{'{OP_ADD, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFD}, 1'b0, '0});
        rows.push_back('{'{OP_CMP, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0});
        rows.push_back('{'{OP_CMP, 16'sd5, -16'sd3, -16'sd7, 16'sd2}, 1'b0, '0});
        rows.push_back('{'{OP_CMP, 16'sd1, 16'sd0, 16'sd1, 16'sd1}, 1'b0, '0});

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_item(rows[k].item);
            // a typed-in result replaces the predicted one, and must agree with it
            if (rows[k].has_golden) begin
                gold = predict_rational(rows[k].item);
                if (gold !== rows[k].golden) begin
                    $error("table row %0d expected %h predictor %h", k, rows[k].golden, gold);
                    fail_count++;
                end
                pending_results[$] = rows[k].golden;
            end
        end

        // random items; a third share related operands so results stay in range
        repeat (NUM_RANDOM) begin
            it.op    = 3'($urandom_range(0, 9) == 0 ? $urandom_range(6, 7)
                                                    : $urandom_range(0, 5));
            it.a_num = draw_part();
            it.a_den = draw_part();
            it.b_num = draw_part();
            it.b_den = draw_part();
            if ($urandom_range(0, 2) == 0) it.b_den = it.a_den;
            send_item(it);
        end
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (400) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
